/* design/touch_event_coalescing_queue_core_macros.svh */
// Assertion macros shared by the checker of the touch event queue
`ifndef TOUCH_EVENT_COALESCING_QUEUE_CORE_MACROS_SVH
`define TOUCH_EVENT_COALESCING_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TECQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch queue check failed");

// Next-cycle implication, sampled on clk, off during reset
`define TECQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch queue check failed");

`endif

/* design/tecq_pkg.sv */
// Shared types and codes of the touch event coalescing queue
`timescale 1ns / 1ps
package tecq_pkg;

	localparam logic [1:0] OP_BEGAN = 2'd0;
	localparam logic [1:0] OP_MOVED = 2'd1;
	localparam logic [1:0] OP_ENDED = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [2:0] KIND_MOUSE_X   = 3'd3;
	localparam logic [2:0] KIND_MOUSE_Y   = 3'd4;
	localparam logic [2:0] KIND_BTN_DOWN  = 3'd5;
	localparam logic [2:0] KIND_BTN_UP    = 3'd6;
	localparam logic [2:0] KIND_MOUSE_POS = 3'd7;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MOUSE_MODE    = 2'd2;

	localparam logic [12:0] PIXEL_MAX      = 13'd8191;
	localparam logic [12:0] WIDTH_RESET    = 13'd1920;
	localparam logic [12:0] HEIGHT_RESET   = 13'd1080;
	localparam logic [15:0] BUTTON_PRESSED = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  finger;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] p;
	} entry_t;

	typedef struct packed {
		logic shift;   // take the neighbor's entry (drain)
		logic merge;   // a move is offered for merging
		logic append;  // write the new item at the tail
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCALE,
		ST_EMIT_A,
		ST_EMIT_B,
		ST_EMIT_C,
		ST_POS
	} state_t;

endpackage

/* design/touch_event_coalescing_queue_core.sv */
// Touch event coalescing queue: top level
// Usage:
//   Items enter on start while busy is low. Began, moved and ended events
//   leave busy low: a move merges into the earliest queued move of its
//   finger, otherwise the event appends, or is dropped when the queue is
//   full and sets the overflow flag.
//   A frame tick raises busy and drains the queue from the head of the cell
//   row, one entry per fetch: fetch, scale (two multipliers), then the entry's
//   results (touch: 1, mouse: 2 or 3, skipped entries 0). In mouse mode the
//   tick ends with a mouse position result. A full queue holds 16 entries.
//   Each result shows on the result ports for one cycle with result_valid,
//   registered in the cycle after it is formed; last marks the final result
//   of the tick. The receiver cannot stall; results are never held back.
//   Registers are written through cfg_write/cfg_index/cfg_data, by the user
//   only while idle; the block does not enforce it. Reset empties the queue,
//   clears the overflow flag, loads the default screen size and centers the
//   mouse at 960, 540.
`timescale 1ns / 1ps
module touch_event_coalescing_queue_core #(
	parameter int QUEUE_DEPTH         = 16,
	parameter int TOUCH_FINGERS       = 10,
	parameter int COORD_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [3:0]         finger,
	input  logic [15:0]        x_position,
	input  logic [15:0]        y_position,
	input  logic [15:0]        pressure,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	output logic               result_valid,
	output logic [2:0]         kind,
	output logic [3:0]         finger_id,
	output logic [12:0]        screen_x,
	output logic [12:0]        screen_y,
	output logic [15:0]        value,
	output logic signed [13:0] delta,
	output logic               last,
	output logic               overflow
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	tecq_pkg::state_t    state_q, state_d;
	logic [CW-1:0]       count_q;
	logic [12:0]         width_q, height_q;
	logic                mode_reg_q, mode_q;
	logic                dropped_q, ovf_q;
	logic [12:0]         mouse_x_q, mouse_y_q;
	tecq_pkg::entry_t    entry_q;
	logic [12:0]         sx_q, sy_q;
	logic [12:0]         sx_c, sy_c;

	tecq_pkg::entry_t    ev;
	tecq_pkg::cell_ctl_t ctl;
	tecq_pkg::entry_t    cell_data [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] hit_chain;
	logic [QUEUE_DEPTH:0] more_chain;

	logic                accept, event_acc, tick_acc, any_hit, room;
	logic                fetch, mouse_upd;
	logic                res_load;
	logic [2:0]          res_kind;
	logic [3:0]          res_finger;
	logic [12:0]         res_x, res_y;
	logic [15:0]         res_value;
	logic [13:0]         res_delta;
	logic                res_last;

	assign busy      = state_q != tecq_pkg::ST_IDLE;
	assign accept    = start && !busy;
	assign tick_acc  = accept && (operation == tecq_pkg::OP_TICK);
	assign event_acc = accept && (operation != tecq_pkg::OP_TICK);
	assign any_hit   = hit_chain[QUEUE_DEPTH] && (operation == tecq_pkg::OP_MOVED);
	assign room      = count_q < CW'(QUEUE_DEPTH);

	assign ev.op     = operation;
	assign ev.finger = finger;
	assign ev.x      = x_position;
	assign ev.y      = y_position;
	assign ev.p      = pressure;

	assign ctl.shift  = fetch;
	assign ctl.merge  = event_acc && (operation == tecq_pkg::OP_MOVED);
	assign ctl.append = event_acc && !any_hit && room;

	assign hit_chain[0]            = 1'b0;
	assign more_chain[QUEUE_DEPTH] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		tecq_cell #(
			.IDX(i),
			.CW(CW),
			.TOUCH_FINGERS(TOUCH_FINGERS)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.count(count_q),
			.ev(ev),
			.nbr((i == QUEUE_DEPTH - 1) ? cell_data[i] : cell_data[(i + 1) % QUEUE_DEPTH]),
			.hit_in(hit_chain[i]),
			.hit_out(hit_chain[i + 1]),
			.more_in(more_chain[i + 1]),
			.more_out(more_chain[i]),
			.data(cell_data[i])
		);
	end

	tecq_scaler #(.FRAC_BITS(COORD_FRACTION_BITS)) u_scale_x (
		.pos(entry_q.x),
		.size(width_q),
		.pixel(sx_c)
	);

	tecq_scaler #(.FRAC_BITS(COORD_FRACTION_BITS)) u_scale_y (
		.pos(entry_q.y),
		.size(height_q),
		.pixel(sy_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tecq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fetch      = 1'b0;
		mouse_upd  = 1'b0;
		res_load   = 1'b0;
		res_kind   = {1'b0, entry_q.op};
		res_finger = entry_q.finger;
		res_x      = sx_q;
		res_y      = sy_q;
		res_value  = '0;
		res_delta  = '0;
		res_last   = 1'b0;
		case (state_q)
			tecq_pkg::ST_IDLE: begin
				if (tick_acc) begin
					state_d = tecq_pkg::ST_FETCH;
				end
			end
			tecq_pkg::ST_FETCH: begin
				if (count_q != '0) begin
					fetch   = 1'b1;
					state_d = tecq_pkg::ST_SCALE;
				end else if (mode_q) begin
					state_d = tecq_pkg::ST_POS;
				end else begin
					state_d = tecq_pkg::ST_IDLE;
				end
			end
			tecq_pkg::ST_SCALE: begin
				// skip entries that give no result in the current mode
				if (mode_q) begin
					state_d = (entry_q.finger == '0) ? tecq_pkg::ST_EMIT_A
					                                 : tecq_pkg::ST_FETCH;
				end else begin
					state_d = ({1'b0, entry_q.finger} < 5'(TOUCH_FINGERS))
					          ? tecq_pkg::ST_EMIT_A : tecq_pkg::ST_FETCH;
				end
			end
			tecq_pkg::ST_EMIT_A: begin
				res_load = 1'b1;
				state_d  = tecq_pkg::ST_FETCH;
				if (mode_q) begin
					res_kind   = tecq_pkg::KIND_MOUSE_X;
					res_finger = '0;
					res_delta  = {1'b0, sx_q} - {1'b0, mouse_x_q};
					state_d    = tecq_pkg::ST_EMIT_B;
				end else begin
					res_value = entry_q.p;
					// the cells already hold only what follows this entry
					res_last  = !more_chain[0];
				end
			end
			tecq_pkg::ST_EMIT_B: begin
				res_load   = 1'b1;
				mouse_upd  = 1'b1;
				res_kind   = tecq_pkg::KIND_MOUSE_Y;
				res_finger = '0;
				res_delta  = {1'b0, sy_q} - {1'b0, mouse_y_q};
				if (entry_q.op == tecq_pkg::OP_BEGAN || entry_q.op == tecq_pkg::OP_ENDED) begin
					state_d = tecq_pkg::ST_EMIT_C;
				end else begin
					state_d = tecq_pkg::ST_FETCH;
				end
			end
			tecq_pkg::ST_EMIT_C: begin
				res_load   = 1'b1;
				res_finger = '0;
				if (entry_q.op == tecq_pkg::OP_BEGAN) begin
					res_kind  = tecq_pkg::KIND_BTN_DOWN;
					res_value = tecq_pkg::BUTTON_PRESSED;
				end else begin
					res_kind  = tecq_pkg::KIND_BTN_UP;
				end
				state_d = tecq_pkg::ST_FETCH;
			end
			tecq_pkg::ST_POS: begin
				res_load   = 1'b1;
				res_kind   = tecq_pkg::KIND_MOUSE_POS;
				res_finger = '0;
				res_x      = mouse_x_q;
				res_y      = mouse_y_q;
				res_last   = 1'b1;
				state_d    = tecq_pkg::ST_IDLE;
			end
			default: begin
				state_d = tecq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			dropped_q    <= 1'b0;
			ovf_q        <= 1'b0;
			mode_q       <= 1'b0;
			width_q      <= tecq_pkg::WIDTH_RESET;
			height_q     <= tecq_pkg::HEIGHT_RESET;
			mode_reg_q   <= 1'b0;
			mouse_x_q    <= tecq_pkg::WIDTH_RESET >> 1;
			mouse_y_q    <= tecq_pkg::HEIGHT_RESET >> 1;
			result_valid <= 1'b0;
		end else begin
			result_valid <= res_load;
			if (cfg_write) begin
				case (cfg_index)
					tecq_pkg::REG_SCREEN_WIDTH:  width_q    <= cfg_data;
					tecq_pkg::REG_SCREEN_HEIGHT: height_q   <= cfg_data;
					tecq_pkg::REG_MOUSE_MODE:    mode_reg_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (tick_acc) begin
				ovf_q     <= dropped_q;
				mode_q    <= mode_reg_q;
				dropped_q <= 1'b0;
			end else if (event_acc && !any_hit) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (fetch) begin
				count_q <= count_q - CW'(1);
			end
			if (mouse_upd) begin
				mouse_x_q <= sx_q;
				mouse_y_q <= sy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch) begin
			entry_q <= cell_data[0];
		end
		if (state_q == tecq_pkg::ST_SCALE) begin
			sx_q <= sx_c;
			sy_q <= sy_c;
		end
		if (res_load) begin
			kind      <= res_kind;
			finger_id <= res_finger;
			screen_x  <= res_x;
			screen_y  <= res_y;
			value     <= res_value;
			delta     <= res_delta;
			last      <= res_last;
			overflow  <= ovf_q;
		end
	end

endmodule

/* design/tecq_cell.sv */
// One queue slot: holds an entry, merges moves, shifts toward the head
`timescale 1ns / 1ps
module tecq_cell #(
	parameter int IDX           = 0,
	parameter int CW            = 5,
	parameter int TOUCH_FINGERS = 10
) (
	input  logic              clk,
	input  tecq_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]     count,
	input  tecq_pkg::entry_t  ev,
	input  tecq_pkg::entry_t  nbr,
	input  logic              hit_in,
	output logic              hit_out,
	input  logic              more_in,
	output logic              more_out,
	output tecq_pkg::entry_t  data
);

	tecq_pkg::entry_t entry_q;
	logic             occupied;
	logic             match;

	assign occupied = CW'(IDX) < count;
	assign match    = occupied && (entry_q.op == tecq_pkg::OP_MOVED) &&
	                  (entry_q.finger == ev.finger);
	assign hit_out  = hit_in | match;
	assign more_out = more_in |
	                  (occupied && ({1'b0, entry_q.finger} < 5'(TOUCH_FINGERS)));
	assign data     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= nbr;
		end else if (ctl.merge && match && !hit_in) begin
			// earliest queued move of this finger takes the new position
			entry_q.x <= ev.x;
			entry_q.y <= ev.y;
			entry_q.p <= ev.p;
		end else if (ctl.append && (CW'(IDX) == count)) begin
			entry_q <= ev;
		end
	end

endmodule

/* design/tecq_scaler.sv */
// Scales a normalized coordinate to a saturated screen pixel
`timescale 1ns / 1ps
module tecq_scaler #(
	parameter int FRAC_BITS = 16
) (
	input  logic [15:0] pos,
	input  logic [12:0] size,
	output logic [12:0] pixel
);

	logic [28:0] prod;
	logic [28:0] shifted;

	assign prod    = 29'(pos) * 29'(size);
	assign shifted = prod >> FRAC_BITS;
	assign pixel   = (shifted > 29'(tecq_pkg::PIXEL_MAX)) ? tecq_pkg::PIXEL_MAX
	                                                      : shifted[12:0];

endmodule

/* design/tecq_checker.sv */
// Port-level checks of the touch event queue, bound to the top level
`timescale 1ns / 1ps
`include "touch_event_coalescing_queue_core_macros.svh"
module tecq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] operation,
	input logic       result_valid,
	input logic [2:0] kind,
	input logic       last
);

	`TECQ_ASSERT_NEXT(a_event_one_cycle, start && !busy && operation != tecq_pkg::OP_TICK, !busy)
	`TECQ_ASSERT_NEXT(a_tick_goes_busy, start && !busy && operation == tecq_pkg::OP_TICK, busy)
	`TECQ_ASSERT_NEXT(a_gap_after_last, result_valid && last, !result_valid)
	`TECQ_ASSERT_NOW(a_position_is_last, result_valid && kind == tecq_pkg::KIND_MOUSE_POS, last)

endmodule

bind touch_event_coalescing_queue_core tecq_checker u_tecq_checker (.*);
